@@ src/dvu_pkg.sv @@
// Package for the distance vector update core: beat types, parser positions and constants.
// Depends on nothing; the core and dvu_relax import it.
`timescale 1ns / 1ps
`default_nettype none

package dvu_pkg;

    localparam logic        MODE_LOAD = 1'b0;
    localparam logic        MODE_BYTE = 1'b1;
    localparam logic [31:0] COST_NONE = 32'hFFFF_FFFF;
    localparam logic [31:0] COST_MAX  = 32'h7FFF_FFFF;
    localparam logic [31:0] COST_MIN  = 32'h8000_0000;

    typedef enum logic [2:0] {
        POS_SOURCE = 3'd0,
        POS_DEST   = 3'd1,
        POS_COUNT  = 3'd2,
        POS_TARGET = 3'd3,
        POS_COST0  = 3'd4,
        POS_COST1  = 3'd5,
        POS_COST2  = 3'd6,
        POS_COST3  = 3'd7
    } parse_pos_t;

    typedef struct packed {
        logic               mode;
        logic [7:0]         node_index;
        logic signed [31:0] link_cost;
        logic [7:0]         packet_byte;
    } in_beat_t;

    typedef struct packed {
        logic [7:0]         target_node;
        logic signed [31:0] new_cost;
        logic               improved;
        logic               last_entry;
        logic               packet_changed;
    } out_beat_t;

    typedef struct packed {
        logic signed [31:0] new_cost;
        logic signed [31:0] sum_cost;
        logic               improved;
    } relax_t;

endpackage

`default_nettype wire

@@ src/distance_vector_update_core.sv @@
// Distance vector update core: keeps this router's cost row and its direct link costs, and
// relaxes the row with each entry of received distance vector packets, one beat at a time.
// An accepted input beat passes the input register and then the result register on its way
// to its result beat; one beat is accepted per cycle, limited only by the result handshake.
// Reset clears per-entry valid bits, so both tables read as unreachable at once; no
// clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module distance_vector_update_core
    import dvu_pkg::*;
#(
    parameter int NODES = 256
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_beat_t  s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_beat_t      m_data
);

    localparam int          AW         = $clog2(NODES);
    localparam logic [8:0]  NODE_LIMIT = 9'(NODES);

    logic              in_valid_reg;
    in_beat_t          in_reg;
    parse_pos_t        pos_reg, pos_next;
    logic [7:0]        source_reg, source_next;
    logic [7:0]        left_reg, left_next;
    logic [7:0]        target_reg, target_next;
    logic [23:0]       shift_reg, shift_next;
    logic              any_reg, any_next;
    logic              m_valid_reg;
    out_beat_t         m_data_reg;
    out_beat_t         res;
    logic              rd_pending_reg;
    logic              own_rd_ok_reg, dir_rd_ok_reg;
    logic [31:0]       own_hold_reg, own_hold_next;
    logic [31:0]       dir_hold_reg, dir_hold_next;
    logic [31:0]       own_base, dir_base;
    logic [NODES-1:0]  own_vld_reg, dir_vld_reg;
    logic [31:0]       own_rdata, dir_rdata;

    logic              in_load, has_result, fire, issue;
    logic              idx_in, tgt_in, src_in, new_tgt_in;
    logic              load_we, relax_we, own_we, is_final;
    logic [7:0]        left_dec;
    logic [AW-1:0]     own_waddr;
    logic [31:0]       own_wdata;
    relax_t            rel;

    assign in_load    = (in_reg.mode == MODE_LOAD);
    assign is_final   = !in_load && (pos_reg == POS_COST3);
    assign has_result = in_valid_reg && !in_load
                        && (is_final || (pos_reg == POS_COUNT && in_reg.packet_byte == 8'd0));
    assign fire       = in_valid_reg && (!has_result || !m_valid_reg || m_ready);
    assign s_ready    = !in_valid_reg || fire;
    assign m_valid    = m_valid_reg;
    assign m_data     = m_data_reg;

    assign idx_in     = {1'b0, in_reg.node_index} < NODE_LIMIT;
    assign tgt_in     = {1'b0, target_reg} < NODE_LIMIT;
    assign src_in     = {1'b0, source_reg} < NODE_LIMIT;
    assign new_tgt_in = {1'b0, in_reg.packet_byte} < NODE_LIMIT;

    assign load_we  = fire && in_load && idx_in;
    assign issue    = fire && !in_load && (pos_reg == POS_TARGET);
    assign relax_we = fire && is_final && rel.improved;
    assign own_we   = load_we || relax_we;
    assign own_waddr = in_load ? in_reg.node_index[AW-1:0] : target_reg[AW-1:0];
    assign own_wdata = in_load ? in_reg.link_cost : rel.sum_cost;

    dvu_ram #(
        .WIDTH (32),
        .DEPTH (NODES)
    ) u_own_ram (
        .aclk  (aclk),
        .we    (own_we),
        .waddr (own_waddr),
        .wdata (own_wdata),
        .re    (issue),
        .raddr (in_reg.packet_byte[AW-1:0]),
        .rdata (own_rdata)
    );

    dvu_ram #(
        .WIDTH (32),
        .DEPTH (NODES)
    ) u_dir_ram (
        .aclk  (aclk),
        .we    (load_we),
        .waddr (in_reg.node_index[AW-1:0]),
        .wdata (in_reg.link_cost),
        .re    (issue),
        .raddr (source_reg[AW-1:0]),
        .rdata (dir_rdata)
    );

    // The costs for an entry are fetched when its target beat passes and are then kept
    // current against any load beats that arrive before the last cost beat.
    always_comb begin
        own_base = rd_pending_reg ? (own_rd_ok_reg ? own_rdata : COST_NONE) : own_hold_reg;
        dir_base = rd_pending_reg ? (dir_rd_ok_reg ? dir_rdata : COST_NONE) : dir_hold_reg;
        own_hold_next = own_base;
        dir_hold_next = dir_base;
        if (load_we && in_reg.node_index == target_reg) begin
            own_hold_next = in_reg.link_cost;
        end
        if (load_we && in_reg.node_index == source_reg) begin
            dir_hold_next = in_reg.link_cost;
        end
    end

    dvu_relax u_relax (
        .link_cost    (dir_hold_reg),
        .adv_cost     ({shift_reg, in_reg.packet_byte}),
        .stored_cost  (own_hold_reg),
        .target_valid (tgt_in),
        .result       (rel)
    );

    always_comb begin
        pos_next    = pos_reg;
        source_next = source_reg;
        left_next   = left_reg;
        target_next = target_reg;
        shift_next  = shift_reg;
        any_next    = any_reg;
        left_dec    = left_reg - 8'd1;
        res         = '0;
        case (pos_reg)
            POS_SOURCE: begin
                source_next = in_reg.packet_byte;
                pos_next    = POS_DEST;
            end
            POS_DEST: begin
                pos_next = POS_COUNT;
            end
            POS_COUNT: begin
                any_next = 1'b0;
                if (in_reg.packet_byte == 8'd0) begin
                    left_next      = 8'd0;
                    pos_next       = POS_SOURCE;
                    res.last_entry = 1'b1;
                end else begin
                    left_next = in_reg.packet_byte;
                    pos_next  = POS_TARGET;
                end
            end
            POS_TARGET: begin
                target_next = in_reg.packet_byte;
                shift_next  = '0;
                pos_next    = POS_COST0;
            end
            POS_COST0: begin
                shift_next = {shift_reg[15:0], in_reg.packet_byte};
                pos_next   = POS_COST1;
            end
            POS_COST1: begin
                shift_next = {shift_reg[15:0], in_reg.packet_byte};
                pos_next   = POS_COST2;
            end
            POS_COST2: begin
                shift_next = {shift_reg[15:0], in_reg.packet_byte};
                pos_next   = POS_COST3;
            end
            POS_COST3: begin
                left_next          = left_dec;
                shift_next         = '0;
                any_next           = any_reg | rel.improved;
                pos_next           = (left_dec == 8'd0) ? POS_SOURCE : POS_TARGET;
                res.target_node    = target_reg;
                res.new_cost       = rel.new_cost;
                res.improved       = rel.improved;
                res.last_entry     = (left_dec == 8'd0);
                res.packet_changed = (left_dec == 8'd0) && (any_reg | rel.improved);
            end
            default: begin
                pos_next = POS_SOURCE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
            pos_reg        <= POS_SOURCE;
            source_reg     <= '0;
            left_reg       <= '0;
            target_reg     <= '0;
            shift_reg      <= '0;
            any_reg        <= 1'b0;
            rd_pending_reg <= 1'b0;
            own_vld_reg    <= '0;
            dir_vld_reg    <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (fire && has_result) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (fire && !in_load) begin
                pos_reg    <= pos_next;
                source_reg <= source_next;
                left_reg   <= left_next;
                target_reg <= target_next;
                shift_reg  <= shift_next;
                any_reg    <= any_next;
            end
            rd_pending_reg <= issue;
            if (own_we) begin
                own_vld_reg[own_waddr] <= 1'b1;
            end
            if (load_we) begin
                dir_vld_reg[in_reg.node_index[AW-1:0]] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_reg <= s_data;
        end
        if (fire && has_result) begin
            m_data_reg <= res;
        end
        if (issue) begin
            own_rd_ok_reg <= new_tgt_in && own_vld_reg[in_reg.packet_byte[AW-1:0]];
            dir_rd_ok_reg <= src_in && dir_vld_reg[source_reg[AW-1:0]];
        end
        own_hold_reg <= own_hold_next;
        dir_hold_reg <= dir_hold_next;
    end

endmodule

`default_nettype wire

@@ src/dvu_ram.sv @@
// Generic single write port RAM with one registered read port.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module dvu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

@@ src/dvu_relax.sv @@
// Relaxation of one distance vector entry: saturating sum and signed compare.
// Depends on dvu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dvu_relax
    import dvu_pkg::*;
(
    input  wire logic signed [31:0] link_cost,
    input  wire logic signed [31:0] adv_cost,
    input  wire logic signed [31:0] stored_cost,
    input  wire logic               target_valid,
    output relax_t                  result
);

    logic signed [32:0] sum_wide;
    logic signed [31:0] sum_sat;
    logic               better;

    always_comb begin
        sum_wide = {link_cost[31], link_cost} + {adv_cost[31], adv_cost};
        if (sum_wide[32] != sum_wide[31]) begin
            sum_sat = sum_wide[32] ? COST_MIN : COST_MAX;
        end else begin
            sum_sat = sum_wide[31:0];
        end
        better = target_valid && ((sum_sat < stored_cost) || (stored_cost == COST_NONE));
        result.sum_cost = sum_sat;
        result.improved = better;
        if (better) begin
            result.new_cost = sum_sat;
        end else if (target_valid) begin
            result.new_cost = stored_cost;
        end else begin
            result.new_cost = COST_NONE;
        end
    end

endmodule

`default_nettype wire
